// ===== rtl/core/lprr_pkg.sv =====
// ----------------------------------------------------------------------------
// lprr_pkg
// Shared constants and the trig table generator of the phase ramp rotator.
// ----------------------------------------------------------------------------
`default_nettype none

package lprr_pkg;

  // Width of a Q1.15 trig value that may reach +1.0 (32768)
  localparam int unsigned TrigW = 17;

  localparam int unsigned CordicIters = 24;
  localparam longint      CordicGain  = 64'sd652032874;

  // atan(2^-i) in units of 2^-32 turn
  localparam longint AtanTurns [CordicIters] = '{
    64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756,
    64'sd42667331,  64'sd21354465,  64'sd10679838,  64'sd5340245,
    64'sd2670163,   64'sd1335087,   64'sd667544,    64'sd333772,
    64'sd166886,    64'sd83443,     64'sd41722,     64'sd20861,
    64'sd10430,     64'sd5215,      64'sd2608,      64'sd1304,
    64'sd652,       64'sd326,       64'sd163,       64'sd81
  };

  // Table entry {sin, cos} in Q1.15 for angle idx / 2^tbits turn.
  // Evaluated at elaboration only: fold, CORDIC in Q2.30, round half up.
  function automatic logic [2*TrigW-1:0] trig_entry(input int unsigned idx,
                                                      input int unsigned tbits);
    logic [31:0] ang;
    logic [1:0]  quad;
    logic        flip;
    longint      x;
    longint      y;
    longint      z;
    longint      nx;
    longint      c;
    longint      s;
    ang  = 32'(idx << (32 - tbits));
    quad = ang[31:30];
    flip = (quad == 2'd1) || (quad == 2'd2);
    if (flip) begin
      ang = ang + 32'h8000_0000;
    end
    z = longint'(signed'(ang));
    x = CordicGain;
    y = 64'sd0;
    for (int i = 0; i < CordicIters; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - AtanTurns[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + AtanTurns[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = (x + 64'sd16384) >>> 15;
    s = (y + 64'sd16384) >>> 15;
    return {s[TrigW-1:0], c[TrigW-1:0]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lprr_trig_table.sv =====
// ----------------------------------------------------------------------------
// lprr_trig_table
// Constant cos/sin lookup over a full turn with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lprr_trig_table #(
  parameter int unsigned TRIG_BITS = 10
) (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic [TRIG_BITS-1:0]              addr_i,
  output logic signed [lprr_pkg::TrigW-1:0]      cos_o,
  output logic signed [lprr_pkg::TrigW-1:0]      sin_o
);
  import lprr_pkg::*;

  localparam int unsigned Depth = 2 ** TRIG_BITS;

  logic [2*TrigW-1:0] trig_lut [Depth];
  logic [2*TrigW-1:0] rd_q;

  for (genvar g = 0; g < Depth; g++) begin : g_lut
    assign trig_lut[g] = trig_entry(32'(g), TRIG_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd_q <= trig_lut[addr_i];
    end
  end

  assign cos_o = signed'(rd_q[TrigW-1:0]);
  assign sin_o = signed'(rd_q[2*TrigW-1:TrigW]);

endmodule

`default_nettype wire

// ===== rtl/core/linear_phase_ramp_rotator.sv =====
// ----------------------------------------------------------------------------
// linear_phase_ramp_rotator
// Rotates complex channel samples by a baseline offset plus a linear phase ramp.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one spectral channel per transfer. tuser marks channel
//   zero of a baseline; that transfer loads the phase offset and per-channel
//   step from tdata and restarts the ramp. On all other transfers the offset
//   and step fields are ignored and the kept phase advances by the kept step.
//   Master stream carries the rotated sample, rounded and saturated.
//   The result is presented on the master side through four register
//   stages (input/phase, trig table read, products, round and saturate).
//   Throughput: one transfer per clock while the master side takes results;
//   the phase accumulator add in the input stage is the only loop, and the
//   trig table is read once per item.
//   Each stage has its own valid bit, so bubbles close up and new transfers are
//   taken while a result waits; s_axis_tready drops only when all four stages
//   hold data and the master side is stalled.
//   Reset clears the stage valid bits, the ramp phase and the ramp step; until
//   a first channel arrives the applied phase stays at zero.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_phase_ramp_rotator #(
  parameter int unsigned SAMPLE_BITS     = 16,
  parameter int unsigned PHASE_BITS      = 32,
  parameter int unsigned TRIG_TABLE_BITS = 10
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,

  input  wire logic s_axis_tvalid_i,
  output logic      s_axis_tready_o,
  // [0] first_channel
  input  wire logic s_axis_tuser_i,
  // sample_re, sample_im, phase_offset, phase_step from bit 0 up, zero padded
  input  wire logic [((2*SAMPLE_BITS+2*PHASE_BITS+7)/8)*8-1:0] s_axis_tdata_i,

  output logic      m_axis_tvalid_o,
  input  wire logic m_axis_tready_i,
  // rotated_re, rotated_im from bit 0 up, zero padded
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata_o
);
  import lprr_pkg::*;

  localparam int unsigned S    = SAMPLE_BITS;
  localparam int unsigned P    = PHASE_BITS;
  localparam int unsigned T    = TRIG_TABLE_BITS;
  localparam int unsigned OutW = ((2*S+7)/8)*8;
  localparam int unsigned PW   = S + TrigW;
  localparam int unsigned SumW = PW + 1;
  localparam int unsigned ShW  = SumW - 15;

  localparam logic signed [SumW-1:0] RoundHalf = SumW'(64'sd16384);
  localparam logic signed [ShW-1:0]  SatHi     = ShW'((64'sd1 <<< (S-1)) - 64'sd1);
  localparam logic signed [ShW-1:0]  SatLo     = -SatHi - ShW'(1);

  // Input fields
  logic signed [S-1:0] in_re;
  logic signed [S-1:0] in_im;
  logic [P-1:0]        in_offset;
  logic [P-1:0]        in_step;
  logic                in_first;
  logic                in_xfer;

  assign in_re     = signed'(s_axis_tdata_i[S-1:0]);
  assign in_im     = signed'(s_axis_tdata_i[2*S-1:S]);
  assign in_offset = s_axis_tdata_i[2*S+P-1:2*S];
  assign in_step   = s_axis_tdata_i[2*S+2*P-1:2*S+P];
  assign in_first  = s_axis_tuser_i;

  // Stage valid bits and ready chain
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || m_axis_tready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign s_axis_tready_o = rdy1;
  assign in_xfer         = s_axis_tvalid_i && rdy1;

  // Stage 1: ramp state and sample. ramp_phase_q is the phase applied to the
  // sample held in stage 1.
  logic [P-1:0]        ramp_phase_q, ramp_phase_d;
  logic [P-1:0]        ramp_step_q, ramp_step_d;
  logic signed [S-1:0] re1_q, im1_q;

  always_comb begin
    ramp_phase_d = ramp_phase_q;
    ramp_step_d  = ramp_step_q;
    if (in_xfer) begin
      if (in_first) begin
        ramp_phase_d = in_offset;
        ramp_step_d  = in_step;
      end else begin
        ramp_phase_d = ramp_phase_q + ramp_step_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_phase_q <= '0;
      ramp_step_q  <= '0;
      v1_q         <= 1'b0;
    end else begin
      ramp_phase_q <= ramp_phase_d;
      ramp_step_q  <= ramp_step_d;
      if (rdy1) begin
        v1_q <= s_axis_tvalid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      re1_q <= in_re;
      im1_q <= in_im;
    end
  end

  // Round the phase to a table index (half up, wrapping) when it is wider than the index
  logic [T-1:0] trig_idx;

  if (P > T) begin : g_idx_round
    assign trig_idx = ramp_phase_q[P-1:P-T] + T'(ramp_phase_q[P-T-1]);
  end else if (P == T) begin : g_idx_same
    assign trig_idx = ramp_phase_q;
  end else begin : g_idx_shift
    assign trig_idx = {ramp_phase_q, {(T-P){1'b0}}};
  end

  // Stage 2: trig table read
  logic                    adv2;
  logic signed [TrigW-1:0] cos2, sin2;
  logic signed [S-1:0]     re2_q, im2_q;

  assign adv2 = rdy2 && v1_q;

  lprr_trig_table #(
    .TRIG_BITS (T)
  ) u_trig_table (
    .clk_i  (clk_i),
    .en_i   (adv2),
    .addr_i (trig_idx),
    .cos_o  (cos2),
    .sin_o  (sin2)
  );

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      re2_q <= re1_q;
      im2_q <= im1_q;
    end
  end

  // Stage 3: products
  logic                 adv3;
  logic signed [PW-1:0] p_rc_q, p_is_q, p_rs_q, p_ic_q;

  assign adv3 = rdy3 && v2_q;

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      p_rc_q <= PW'(re2_q) * PW'(cos2);
      p_is_q <= PW'(im2_q) * PW'(sin2);
      p_rs_q <= PW'(re2_q) * PW'(sin2);
      p_ic_q <= PW'(im2_q) * PW'(cos2);
    end
  end

  // Stage 4: sum, round half up, saturate
  logic                   adv4;
  logic signed [SumW-1:0] sum_re, sum_im;
  logic signed [ShW-1:0]  sh_re, sh_im;
  logic signed [S-1:0]    rot_re_d, rot_im_d;
  logic signed [S-1:0]    rot_re_q, rot_im_q;

  assign adv4   = rdy4 && v3_q;
  assign sum_re = SumW'(p_rc_q) - SumW'(p_is_q) + RoundHalf;
  assign sum_im = SumW'(p_rs_q) + SumW'(p_ic_q) + RoundHalf;
  assign sh_re  = signed'(sum_re[SumW-1:15]);
  assign sh_im  = signed'(sum_im[SumW-1:15]);

  always_comb begin
    if (sh_re > SatHi) begin
      rot_re_d = SatHi[S-1:0];
    end else if (sh_re < SatLo) begin
      rot_re_d = SatLo[S-1:0];
    end else begin
      rot_re_d = sh_re[S-1:0];
    end
    if (sh_im > SatHi) begin
      rot_im_d = SatHi[S-1:0];
    end else if (sh_im < SatLo) begin
      rot_im_d = SatLo[S-1:0];
    end else begin
      rot_im_d = sh_im[S-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv4) begin
      rot_re_q <= rot_re_d;
      rot_im_q <= rot_im_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  assign m_axis_tvalid_o = v4_q;
  assign m_axis_tdata_o  = OutW'({rot_im_q, rot_re_q});

  // Assertions
  a_ramp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_xfer |=> $stable(ramp_phase_q) && $stable(ramp_step_q))
    else $error("ramp state changed without an input transfer");

  a_ramp_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_first |=> ramp_phase_q == $past(in_offset)
                            && ramp_step_q == $past(in_step))
    else $error("first channel did not load offset and step");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q && !m_axis_tready_i |=> v4_q && $stable(rot_re_q) && $stable(rot_im_q))
    else $error("stalled result was lost or changed");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> v1_q && v2_q && v3_q && v4_q && !m_axis_tready_i)
    else $error("input stalled while the pipeline has room");

endmodule

`default_nettype wire

// ===== dv/lprr_rotation_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lprr_rotation_checker
// Watches both streams of the phase ramp rotator, keeps its own copy of the
// ramp phase and step, predicts each rotated sample and compares it field by
// field with the next result in order.
// ----------------------------------------------------------------------------

module lprr_rotation_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        in_first_i,
  // sample_re, sample_im, phase_offset, phase_step from bit 0 up
  input  logic [95:0] in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  // rotated_re, rotated_im from bit 0 up
  input  logic [31:0] out_data_i,
  output int          error_count_o,
  output int          pending_o
);

  localparam int unsigned CordicSteps = 24;
  localparam longint      CordicStart = 64'sd652032874;
  localparam longint      RoundHalf   = 64'sd16384;
  localparam longint      SampleMax   = 64'sd32767;
  localparam longint      SampleMin   = -64'sd32768;

  // atan(2^-i) in 2^-32 turn
  localparam longint AtanStep [CordicSteps] = '{
    64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756,
    64'sd42667331,  64'sd21354465,  64'sd10679838,  64'sd5340245,
    64'sd2670163,   64'sd1335087,   64'sd667544,    64'sd333772,
    64'sd166886,    64'sd83443,     64'sd41722,     64'sd20861,
    64'sd10430,     64'sd5215,      64'sd2608,      64'sd1304,
    64'sd652,       64'sd326,       64'sd163,       64'sd81
  };

  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
    int                 item;
  } rotation_t;

  rotation_t   expected_rotations[$];
  logic [31:0] ramp_acc;
  logic [31:0] ramp_inc;
  int          items_seen = 0;
  int          errors = 0;
  int          waiting = 0;

  assign error_count_o = errors;
  assign pending_o     = waiting;

  task automatic report_mismatch(input string msg);
    $display("[%0t] rotation check: %s", $time, msg);
    errors++;
  endtask

  function automatic logic signed [15:0] saturate_q15(input longint v);
    if (v > SampleMax) begin
      return 16'sh7fff;
    end else if (v < SampleMin) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // Rotate one sample by a 32-bit turn phase: round the phase to a 10-bit
  // table index, derive cos/sin by CORDIC in Q2.30, then round and saturate.
  function automatic void predict_rotation(input logic signed [15:0] re_in,
                                           input logic signed [15:0] im_in,
                                           input logic [31:0] phase,
                                           output logic signed [15:0] re_out,
                                           output logic signed [15:0] im_out);
    logic [11:0] idx_sum;
    logic [31:0] angle;
    logic        flip;
    longint      x;
    longint      y;
    longint      z;
    longint      nx;
    longint      cos_q;
    longint      sin_q;
    longint      re_l;
    longint      im_l;
    idx_sum = {1'b0, phase[31:21]} + 12'd1;
    angle   = {idx_sum[10:1], 22'd0};
    flip    = (angle[31:30] == 2'd1) || (angle[31:30] == 2'd2);
    if (flip) begin
      angle = angle + 32'h8000_0000;
    end
    z = longint'(signed'(angle));
    x = CordicStart;
    y = 0;
    for (int i = 0; i < CordicSteps; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - AtanStep[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + AtanStep[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cos_q  = (x + RoundHalf) >>> 15;
    sin_q  = (y + RoundHalf) >>> 15;
    re_l   = re_in;
    im_l   = im_in;
    re_out = saturate_q15((re_l * cos_q - im_l * sin_q + RoundHalf) >>> 15);
    im_out = saturate_q15((re_l * sin_q + im_l * cos_q + RoundHalf) >>> 15);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rotation_t want;
    rotation_t got;
    if (!rst_ni) begin
      ramp_acc = '0;
      ramp_inc = '0;
    end else begin
      // compare first: a result always belongs to an older transfer
      if (out_valid_i && out_ready_i) begin
        got.re = out_data_i[15:0];
        got.im = out_data_i[31:16];
        if (expected_rotations.size() == 0) begin
          report_mismatch($sformatf("result re=%0d im=%0d with no item pending",
                                    got.re, got.im));
        end else begin
          want = expected_rotations.pop_front();
          if (got.re !== want.re) begin
            report_mismatch($sformatf("item %0d rotated_re got %0d want %0d",
                                      want.item, got.re, want.re));
          end
          if (got.im !== want.im) begin
            report_mismatch($sformatf("item %0d rotated_im got %0d want %0d",
                                      want.item, got.im, want.im));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_first_i) begin
          ramp_acc = in_data_i[63:32];
          ramp_inc = in_data_i[95:64];
        end else begin
          ramp_acc = ramp_acc + ramp_inc;
        end
        predict_rotation(in_data_i[15:0], in_data_i[31:16], ramp_acc,
                         want.re, want.im);
        want.item = items_seen;
        expected_rotations.push_back(want);
        items_seen++;
      end
      waiting = expected_rotations.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives channel samples into the phase ramp rotator: a directed part for
// ramp start, wrap, ignored fields and saturation, then random baselines of
// random length, with random gaps and back-pressure on both streams.
// ----------------------------------------------------------------------------

module testbench;

  localparam int          RandomItems = 1550;
  localparam int          IdleLimit   = 1000;
  localparam int          DrainCycles = 12;
  localparam logic [31:0] QuarterTurn = 32'h4000_0000;
  localparam logic [31:0] HalfTurn    = 32'h8000_0000;
  localparam logic [31:0] AllOnes     = 32'hffff_ffff;
  localparam logic [15:0] PosFull     = 16'h7fff;
  localparam logic [15:0] NegFull     = 16'h8000;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic        s_tuser = 1'b0;
  logic [95:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  int          error_count;
  int          pending;
  int          sent_count = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;
  bit          quiet_run = 1'b0;

  linear_phase_ramp_rotator dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  lprr_rotation_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (s_tvalid),
    .in_ready_i    (s_tready),
    .in_first_i    (s_tuser),
    .in_data_i     (s_tdata),
    .out_valid_i   (m_tvalid),
    .out_ready_i   (m_tready),
    .out_data_i    (m_tdata),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_run || r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 19))
      0: return PosFull;
      1: return NegFull;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Hold the transfer until it is taken; valid stays high into the next call
  // unless that call opens a gap.
  task automatic send_channel(input logic first, input logic [15:0] re,
                              input logic [15:0] im, input logic [31:0] offset,
                              input logic [31:0] step);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= first;
    s_tdata  <= {step, offset, im, re};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_count++;
  endtask

  // Sink back-pressure: mostly short stalls, a few long ones, none when quiet.
  always @(posedge clk) begin
    int r;
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet_run && $urandom_range(0, 99) < 15) begin
      r = $urandom_range(0, 99);
      m_tready <= 1'b0;
      if (r < 80) begin
        stall_left <= $urandom_range(0, 2);
      end else if (r < 97) begin
        stall_left <= $urandom_range(3, 11);
      end else begin
        stall_left <= $urandom_range(29, 79);
      end
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no transfer for %0d cycles", IdleLimit);
        $display("** linear_phase_ramp_rotator: FAILED **");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int          run_len;
    logic [31:0] step_word;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ramp from reset: phase stays zero, offset and step fields ignored
    send_channel(1'b0, PosFull, NegFull, $urandom(), $urandom());
    send_channel(1'b0, NegFull, PosFull, AllOnes, AllOnes);
    send_channel(1'b0, 16'h04d2, 16'hfdc9, $urandom(), $urandom());
    // half turn on full scale: saturates
    send_channel(1'b1, NegFull, 16'h0000, HalfTurn, 32'h0);
    send_channel(1'b0, 16'h0000, NegFull, $urandom(), $urandom());
    // quarter-turn ramp through every quadrant
    send_channel(1'b1, PosFull, PosFull, 32'h0, QuarterTurn);
    send_channel(1'b0, NegFull, NegFull, 32'h0, 32'h0);
    send_channel(1'b0, PosFull, NegFull, 32'h0, 32'h0);
    send_channel(1'b0, NegFull, PosFull, 32'h0, 32'h0);
    send_channel(1'b0, 16'h0000, 16'h0000, 32'h0, 32'h0);
    // wrap of the ramp and of the index rounding
    send_channel(1'b1, PosFull, PosFull, AllOnes, AllOnes);
    send_channel(1'b0, 16'hffff, 16'h0001, 32'h0, 32'h0);
    send_channel(1'b0, 16'h0001, 16'hffff, 32'h0, 32'h0);
    // quadrant edge, fine steps
    send_channel(1'b1, NegFull, NegFull, 32'h3fff_ffff, 32'h0020_0000);
    send_channel(1'b0, pick_sample(), pick_sample(), AllOnes, AllOnes);
    send_channel(1'b0, pick_sample(), pick_sample(), AllOnes, AllOnes);
    send_channel(1'b0, pick_sample(), pick_sample(), AllOnes, AllOnes);
    send_channel(1'b1, PosFull, 16'h0000, 32'hc000_0000, 32'h0000_0001);
    // rounding boundary of the table index
    send_channel(1'b1, PosFull, PosFull, 32'h001f_ffff, 32'h0000_0001);
    send_channel(1'b0, PosFull, PosFull, 32'h0, 32'h0);
    send_channel(1'b1, PosFull, NegFull, 32'h0020_0000, 32'h7fff_ffff);
    send_channel(1'b0, NegFull, NegFull, 32'h0, 32'h0);
    send_channel(1'b0, PosFull, PosFull, 32'h0, 32'h0);

    // random baselines
    while (sent_count < RandomItems) begin
      quiet_run = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) begin
        run_len = $urandom_range(33, 128);
      end else begin
        run_len = $urandom_range(0, 32);
      end
      case ($urandom_range(0, 3))
        0: step_word = $urandom();
        1: step_word = $urandom_range(0, 32'h0100_0000);
        2: step_word = QuarterTurn * $urandom_range(0, 3);
        default: step_word = AllOnes - $urandom_range(0, 32'h0010_0000);
      endcase
      send_channel(1'b1, pick_sample(), pick_sample(), $urandom(), step_word);
      for (int k = 0; k < run_len; k++) begin
        send_channel(1'b0, pick_sample(), pick_sample(), $urandom(), $urandom());
      end
    end
    s_tvalid <= 1'b0;
    quiet_run = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("** linear_phase_ramp_rotator: PASSED **");
    end else begin
      $display("** linear_phase_ramp_rotator: FAILED **");
    end
    $finish;
  end

endmodule
